/* design/sld_pkg.sv */
// Package for the serial loop display device.
// Holds the frame classes, command and ready codes, register map and reset values.
// No dependencies.
package sld_pkg;

   localparam int unsigned FRAME_W = 11;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned ADDR_W  = 5;
   localparam int unsigned PTR_W   = 4;
   localparam int unsigned ID_W    = 64;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 5;

   localparam logic [FRAME_W-1:0] FRAME_EOT = 11'h540;

   typedef enum logic [2:0] {
      CLS_CMD   = 3'b100,
      CLS_READY = 3'b101
   } frame_class_type;

   typedef enum logic [2:0] {
      GRP_CTRL   = 3'd0,
      GRP_LISTEN = 3'd1,
      GRP_TALK   = 3'd2,
      GRP_IFC    = 3'd4
   } cmd_group_type;

   localparam logic [BYTE_W-1:0] CMD_SDC = 8'd4;
   localparam logic [BYTE_W-1:0] CMD_DCL = 8'd20;
   localparam logic [ADDR_W-1:0] LOW_UNADDRESS = 5'd31;
   localparam logic [ADDR_W-1:0] LOW_IFC = 5'd16;
   localparam logic [ADDR_W-1:0] LOW_AAU = 5'd26;

   localparam logic [BYTE_W-1:0] RDY_NRD = 8'd66;
   localparam logic [BYTE_W-1:0] RDY_SST = 8'd97;
   localparam logic [BYTE_W-1:0] RDY_SDI = 8'd98;
   localparam logic [BYTE_W-1:0] RDY_SAI = 8'd99;
   localparam logic [BYTE_W-1:0] RDY_TALK_MAX = 8'd127;
   localparam logic [BYTE_W-1:0] RDY_AAD_END = 8'h9E;
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

   typedef enum logic [1:0] {
      REG_ACCESSORY_ID    = 2'd0,
      REG_DEFAULT_ADDRESS = 2'd1,
      REG_DEVICE_STATUS   = 2'd2,
      REG_DEVICE_ID       = 2'd3
   } reg_index_type;

   localparam logic [BYTE_W-1:0] ACCESSORY_ID_RESET    = 8'd46;
   localparam logic [ADDR_W-1:0] DEFAULT_ADDRESS_RESET = 5'd3;
   localparam logic [BYTE_W-1:0] DEVICE_STATUS_RESET   = 8'd0;
   localparam logic [ID_W-1:0]   DEVICE_ID_RESET       = 64'h0D59414C50534944;

endpackage

/* design/serial_loop_display_device.sv */
// Serial loop display device: decodes loop frames, drives the display and answers requests.
// An item waits in the input register until the result register is free, then moves into it.
// Throughput: one item per cycle when unstalled; a stall holds req_stall in the same cycle when full.
// Reset: synchronous, active high; clears loop state and both valid stages; presets the registers.
// Depends on sld_pkg.
module serial_loop_display_device #(
   parameter int unsigned ID_BYTES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sld_pkg::FRAME_W-1:0]         req_in_frame,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sld_pkg::FRAME_W-1:0]         rsp_out_frame,
   output logic                                rsp_show_valid,
   output logic [sld_pkg::BYTE_W-1:0]          rsp_show_char,
   output logic                                rsp_clear_display,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sld_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sld_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sld_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam logic [sld_pkg::PTR_W-1:0] ID_LIMIT = sld_pkg::PTR_W'(ID_BYTES);

   logic                           in_valid_ff;
   logic [sld_pkg::FRAME_W-1:0]    in_frame_ff;
   logic                           out_valid_ff;
   logic [sld_pkg::FRAME_W-1:0]    out_frame_ff;
   logic                           show_valid_ff;
   logic [sld_pkg::BYTE_W-1:0]     show_char_ff;
   logic                           clear_display_ff;

   logic [sld_pkg::FRAME_W-1:0]    out_frame_in;
   logic                           show_valid_in;
   logic [sld_pkg::BYTE_W-1:0]     show_char_in;
   logic                           clear_display_in;

   logic                           listen_flag_ff, listen_flag_in;
   logic                           talk_flag_ff, talk_flag_in;
   logic [sld_pkg::ADDR_W-1:0]     loop_address_ff, loop_address_in;
   logic                           address_assigned_ff, address_assigned_in;
   logic [sld_pkg::PTR_W-1:0]      id_pointer_ff, id_pointer_in;

   logic [sld_pkg::BYTE_W-1:0]     accessory_id_ff;
   logic [sld_pkg::ADDR_W-1:0]     default_address_ff;
   logic [sld_pkg::BYTE_W-1:0]     device_status_ff;
   logic [sld_pkg::ID_W-1:0]       device_id_ff;

   logic                           out_free;
   logic                           proc_fire;
   logic                           req_fire;
   logic                           csr_write;
   sld_pkg::reg_index_type         csr_index;

   logic [sld_pkg::BYTE_W-1:0]     payload;
   logic [sld_pkg::ADDR_W-1:0]     low;
   logic [sld_pkg::PTR_W-1:0]      id_index;
   logic [sld_pkg::BYTE_W-1:0]     id_char;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign proc_fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_frame     = out_frame_ff;
   assign rsp_show_valid    = show_valid_ff;
   assign rsp_show_char     = show_char_ff;
   assign rsp_clear_display = clear_display_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = sld_pkg::reg_index_type'(csr_paddr[4:3]);

   always_comb begin
      case (csr_index)
         sld_pkg::REG_ACCESSORY_ID:    csr_prdata = {56'd0, accessory_id_ff};
         sld_pkg::REG_DEFAULT_ADDRESS: csr_prdata = {59'd0, default_address_ff};
         sld_pkg::REG_DEVICE_STATUS:   csr_prdata = {56'd0, device_status_ff};
         sld_pkg::REG_DEVICE_ID:       csr_prdata = device_id_ff;
         default:                      csr_prdata = '0;
      endcase
   end

   assign payload  = in_frame_ff[7:0];
   assign low      = payload[4:0];
   assign id_index = id_pointer_ff - 4'd1;
   assign id_char  = device_id_ff[8*id_index[2:0] +: 8];

   // Frame decode for the item in the input register.
   always_comb begin
      out_frame_in        = in_frame_ff;
      show_valid_in       = 1'b0;
      show_char_in        = '0;
      clear_display_in    = 1'b0;
      listen_flag_in      = listen_flag_ff;
      talk_flag_in        = talk_flag_ff;
      loop_address_in     = loop_address_ff;
      address_assigned_in = address_assigned_ff;
      id_pointer_in       = id_pointer_ff;

      if (!in_frame_ff[10]) begin
         if (listen_flag_ff && !talk_flag_ff) begin
            show_valid_in = 1'b1;
            show_char_in  = payload;
         end else if (listen_flag_ff && talk_flag_ff) begin
            if (id_pointer_ff != '0) begin
               if (id_index < ID_LIMIT) begin
                  out_frame_in = {3'd0, id_char};
                  if (id_char == sld_pkg::CHAR_CR) begin
                     id_pointer_in = '0;
                  end else begin
                     id_pointer_in = id_pointer_ff + 4'd1;
                  end
               end else begin
                  id_pointer_in = '0;
               end
            end
            if (id_pointer_in == '0) begin
               out_frame_in   = sld_pkg::FRAME_EOT;
               listen_flag_in = 1'b0;
               talk_flag_in   = 1'b1;
            end
         end
      end else if (in_frame_ff[10:8] == sld_pkg::CLS_CMD) begin
         case (sld_pkg::cmd_group_type'(payload[7:5]))
            sld_pkg::GRP_CTRL: begin
               if (payload == sld_pkg::CMD_SDC && listen_flag_ff) begin
                  clear_display_in = 1'b1;
               end
               if (payload == sld_pkg::CMD_DCL) begin
                  clear_display_in = 1'b1;
               end
            end
            sld_pkg::GRP_LISTEN: begin
               if (low == sld_pkg::LOW_UNADDRESS) begin
                  if (!talk_flag_ff) begin
                     listen_flag_in = 1'b0;
                  end
               end else if (low == loop_address_ff) begin
                  listen_flag_in = 1'b1;
                  talk_flag_in   = 1'b0;
               end
            end
            sld_pkg::GRP_TALK: begin
               if (low == loop_address_ff) begin
                  listen_flag_in = 1'b0;
                  talk_flag_in   = 1'b1;
               end else if (talk_flag_ff) begin
                  listen_flag_in = 1'b0;
                  talk_flag_in   = 1'b0;
               end
            end
            sld_pkg::GRP_IFC: begin
               if (low == sld_pkg::LOW_IFC) begin
                  listen_flag_in = 1'b0;
                  talk_flag_in   = 1'b0;
               end else if (low == sld_pkg::LOW_AAU) begin
                  loop_address_in     = default_address_ff;
                  address_assigned_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end else if (in_frame_ff[10:8] == sld_pkg::CLS_READY) begin
         if (payload <= sld_pkg::RDY_TALK_MAX) begin
            if (talk_flag_ff) begin
               case (payload)
                  sld_pkg::RDY_NRD: begin
                     id_pointer_in = '0;
                  end
                  sld_pkg::RDY_SST: begin
                     out_frame_in   = {3'd0, device_status_ff};
                     listen_flag_in = 1'b1;
                  end
                  sld_pkg::RDY_SDI: begin
                     out_frame_in   = {3'd0, device_id_ff[7:0]};
                     id_pointer_in  = 4'd2;
                     listen_flag_in = 1'b1;
                  end
                  sld_pkg::RDY_SAI: begin
                     out_frame_in   = {3'd0, accessory_id_ff};
                     listen_flag_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end else if (payload < sld_pkg::RDY_AAD_END) begin
            if (!address_assigned_ff) begin
               loop_address_in     = low;
               address_assigned_in = 1'b1;
               out_frame_in        = in_frame_ff + 11'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         listen_flag_ff      <= 1'b0;
         talk_flag_ff        <= 1'b0;
         loop_address_ff     <= '0;
         address_assigned_ff <= 1'b0;
         id_pointer_ff       <= '0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (proc_fire) begin
            in_valid_ff <= 1'b0;
         end
         if (proc_fire) begin
            out_valid_ff        <= 1'b1;
            listen_flag_ff      <= listen_flag_in;
            talk_flag_ff        <= talk_flag_in;
            loop_address_ff     <= loop_address_in;
            address_assigned_ff <= address_assigned_in;
            id_pointer_ff       <= id_pointer_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_frame_ff <= req_in_frame;
      end
      if (proc_fire) begin
         out_frame_ff     <= out_frame_in;
         show_valid_ff    <= show_valid_in;
         show_char_ff     <= show_char_in;
         clear_display_ff <= clear_display_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accessory_id_ff    <= sld_pkg::ACCESSORY_ID_RESET;
         default_address_ff <= sld_pkg::DEFAULT_ADDRESS_RESET;
         device_status_ff   <= sld_pkg::DEVICE_STATUS_RESET;
         device_id_ff       <= sld_pkg::DEVICE_ID_RESET;
      end else if (csr_write) begin
         case (csr_index)
            sld_pkg::REG_ACCESSORY_ID:    accessory_id_ff    <= csr_pwdata[7:0];
            sld_pkg::REG_DEFAULT_ADDRESS: default_address_ff <= csr_pwdata[4:0];
            sld_pkg::REG_DEVICE_STATUS:   device_status_ff   <= csr_pwdata[7:0];
            sld_pkg::REG_DEVICE_ID:       device_id_ff       <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   // A display write and a display clear never come from the same item.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && show_valid_ff) |-> !clear_display_ff)
      else $error("display write and clear in one item");

   // The character is zero whenever no display write is requested.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !show_valid_ff) |-> (show_char_ff == '0))
      else $error("show_char nonzero without show_valid");

   // An item held in the input register is not lost while the result side stalls.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |=> in_valid_ff)
      else $error("input item dropped under stall");

   // The address is only assigned while an item is being processed.
   assert property (@(posedge clock) disable iff (reset)
      $rose(address_assigned_ff) |-> $past(proc_fire))
      else $error("address assigned without an item");

   // Both valid stages are empty right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> (!out_valid_ff && !in_valid_ff))
      else $error("valid stage set after reset");

endmodule

/* sim/testbench.sv */
// Testbench for serial_loop_display_device: directed and random loop frames with a
// predictor and an in-order result check. Depends on sld_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned ID_BYTES = 8;
   localparam int unsigned PHASES = 8;
   localparam int unsigned ITEMS_PER_PHASE = 76;
   localparam logic [2:0] CLS_DATA = 3'b000;
   localparam logic [sld_pkg::BYTE_W-1:0] AAD_FIRST = 8'h80;

   typedef struct packed {
      logic [sld_pkg::FRAME_W-1:0] out_frame;
      logic                        show_valid;
      logic [sld_pkg::BYTE_W-1:0]  show_char;
      logic                        clear_display;
   } loop_result_type;

   class loop_state_tracker;
      logic listening;
      logic talking;
      logic assigned;
      logic [sld_pkg::ADDR_W-1:0] my_addr;
      logic [sld_pkg::PTR_W-1:0] id_ptr;
      logic [sld_pkg::BYTE_W-1:0] accessory_id;
      logic [sld_pkg::ADDR_W-1:0] default_addr;
      logic [sld_pkg::BYTE_W-1:0] device_status;
      logic [sld_pkg::ID_W-1:0] device_id;
      loop_result_type expected_results[$];
      int unsigned faults;

      function new();
         listening = 1'b0;
         talking = 1'b0;
         assigned = 1'b0;
         my_addr = '0;
         id_ptr = '0;
         accessory_id = sld_pkg::ACCESSORY_ID_RESET;
         default_addr = sld_pkg::DEFAULT_ADDRESS_RESET;
         device_status = sld_pkg::DEVICE_STATUS_RESET;
         device_id = sld_pkg::DEVICE_ID_RESET;
         faults = 0;
      endfunction

      function void set_register(sld_pkg::reg_index_type which,
                                 logic [sld_pkg::CSR_DATA_W-1:0] value);
         case (which)
            sld_pkg::REG_ACCESSORY_ID: accessory_id = value[sld_pkg::BYTE_W-1:0];
            sld_pkg::REG_DEFAULT_ADDRESS: default_addr = value[sld_pkg::ADDR_W-1:0];
            sld_pkg::REG_DEVICE_STATUS: device_status = value[sld_pkg::BYTE_W-1:0];
            sld_pkg::REG_DEVICE_ID: device_id = value[sld_pkg::ID_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_frame(logic [sld_pkg::FRAME_W-1:0] f);
         loop_result_type r;
         logic [sld_pkg::BYTE_W-1:0] n;
         logic [sld_pkg::ADDR_W-1:0] low;
         logic [sld_pkg::PTR_W-1:0] slot;
         logic [sld_pkg::BYTE_W-1:0] c;
         r = '0;
         r.out_frame = f;
         n = f[sld_pkg::BYTE_W-1:0];
         low = n[sld_pkg::ADDR_W-1:0];
         if (!f[10]) begin
            if (listening && !talking) begin
               r.show_valid = 1'b1;
               r.show_char = n;
            end else if (listening) begin
               if (id_ptr != 0) begin
                  slot = id_ptr - 4'd1;
                  if (slot < ID_BYTES) begin
                     c = device_id[8*slot +: 8];
                     r.out_frame = {CLS_DATA, c};
                     if (c == sld_pkg::CHAR_CR) id_ptr = '0;
                     else id_ptr = id_ptr + 4'd1;
                  end else begin
                     id_ptr = '0;
                  end
               end
               if (id_ptr == 0) begin
                  r.out_frame = sld_pkg::FRAME_EOT;
                  listening = 1'b0;
                  talking = 1'b1;
               end
            end
         end else if (f[10:8] == sld_pkg::CLS_CMD) begin
            case (sld_pkg::cmd_group_type'(n[7:5]))
               sld_pkg::GRP_CTRL: begin
                  if (n == sld_pkg::CMD_SDC && listening) r.clear_display = 1'b1;
                  if (n == sld_pkg::CMD_DCL) r.clear_display = 1'b1;
               end
               sld_pkg::GRP_LISTEN: begin
                  if (low == sld_pkg::LOW_UNADDRESS) begin
                     if (!talking) listening = 1'b0;
                  end else if (low == my_addr) begin
                     listening = 1'b1;
                     talking = 1'b0;
                  end
               end
               sld_pkg::GRP_TALK: begin
                  if (low == my_addr) begin
                     listening = 1'b0;
                     talking = 1'b1;
                  end else if (talking) begin
                     listening = 1'b0;
                     talking = 1'b0;
                  end
               end
               sld_pkg::GRP_IFC: begin
                  if (low == sld_pkg::LOW_IFC) begin
                     listening = 1'b0;
                     talking = 1'b0;
                  end else if (low == sld_pkg::LOW_AAU) begin
                     my_addr = default_addr;
                     assigned = 1'b0;
                  end
               end
               default: ;
            endcase
         end else if (f[10:8] == sld_pkg::CLS_READY) begin
            if (n <= sld_pkg::RDY_TALK_MAX) begin
               if (talking) begin
                  if (n == sld_pkg::RDY_NRD) begin
                     id_ptr = '0;
                  end else if (n == sld_pkg::RDY_SST) begin
                     r.out_frame = {CLS_DATA, device_status};
                     listening = 1'b1;
                  end else if (n == sld_pkg::RDY_SDI) begin
                     r.out_frame = {CLS_DATA, device_id[7:0]};
                     id_ptr = 4'd2;
                     listening = 1'b1;
                  end else if (n == sld_pkg::RDY_SAI) begin
                     r.out_frame = {CLS_DATA, accessory_id};
                     listening = 1'b1;
                  end
               end
            end else if (n < sld_pkg::RDY_AAD_END) begin
               if (!assigned) begin
                  my_addr = low;
                  assigned = 1'b1;
                  r.out_frame = f + 11'd1;
               end
            end
         end
         expected_results.push_back(r);
      endfunction

      function void compare_result(loop_result_type got);
         loop_result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected: frame %h show %b char %h clear %b",
                     $time, got.out_frame, got.show_valid, got.show_char, got.clear_display);
            faults++;
            return;
         end
         want = expected_results.pop_front();
         if (got !== want) begin
            $display("%0t: expected frame %h show %b char %h clear %b", $time,
                     want.out_frame, want.show_valid, want.show_char, want.clear_display);
            $display("%0t: actual   frame %h show %b char %h clear %b", $time,
                     got.out_frame, got.show_valid, got.show_char, got.clear_display);
            faults++;
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [sld_pkg::FRAME_W-1:0] req_in_frame = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [sld_pkg::FRAME_W-1:0] rsp_out_frame;
   logic rsp_show_valid;
   logic [sld_pkg::BYTE_W-1:0] rsp_show_char;
   logic rsp_clear_display;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [sld_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [sld_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [sld_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycles = 0;
   loop_state_tracker tracker;

   serial_loop_display_device #(
      .ID_BYTES(ID_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_frame(req_in_frame),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_frame(rsp_out_frame),
      .rsp_show_valid(rsp_show_valid),
      .rsp_show_char(rsp_show_char),
      .rsp_clear_display(rsp_clear_display),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("serial_loop_display_device verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.compare_result({rsp_out_frame, rsp_show_valid, rsp_show_char,
                                 rsp_clear_display});
      end
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   function automatic logic [sld_pkg::FRAME_W-1:0] data_frame();
      return {1'b0, 2'($urandom), 8'($urandom)};
   endfunction

   task automatic send_frame(logic [sld_pkg::FRAME_W-1:0] f);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_in_frame <= f;
      do @(posedge clock); while (req_stall);
      tracker.take_frame(f);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (tracker.expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(sld_pkg::reg_index_type which,
                            logic [sld_pkg::CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      tracker.set_register(which, value);
   endtask

   task automatic setup_phase(int unsigned p);
      logic [sld_pkg::ID_W-1:0] id;
      int unsigned cr_at;
      id = {$urandom, $urandom};
      cr_at = $urandom_range(ID_BYTES);
      if (cr_at < ID_BYTES) id[8*cr_at +: 8] = sld_pkg::CHAR_CR;
      case (p)
         1: begin
            csr_write(sld_pkg::REG_ACCESSORY_ID, '0);
            csr_write(sld_pkg::REG_DEFAULT_ADDRESS, '0);
            csr_write(sld_pkg::REG_DEVICE_STATUS, '0);
            csr_write(sld_pkg::REG_DEVICE_ID, '0);
         end
         2: begin
            csr_write(sld_pkg::REG_ACCESSORY_ID, 64'hFF);
            csr_write(sld_pkg::REG_DEFAULT_ADDRESS, 64'd30);
            csr_write(sld_pkg::REG_DEVICE_STATUS, 64'hFF);
            csr_write(sld_pkg::REG_DEVICE_ID, '1);
         end
         default: begin
            if (p == 3) id[7:0] = sld_pkg::CHAR_CR;
            csr_write(sld_pkg::REG_ACCESSORY_ID, 64'($urandom_range(255)));
            csr_write(sld_pkg::REG_DEFAULT_ADDRESS, 64'($urandom_range(30)));
            csr_write(sld_pkg::REG_DEVICE_STATUS, 64'($urandom_range(255)));
            csr_write(sld_pkg::REG_DEVICE_ID, id);
         end
      endcase
      case (p % 4)
         0: begin idle_pct = 0; stall_pct = 0; end
         1: begin idle_pct = 62; stall_pct = 0; end
         2: begin idle_pct = 0; stall_pct = 62; end
         default: begin idle_pct = 36; stall_pct = 36; end
      endcase
   endtask

   task automatic directed_frames();
      logic [sld_pkg::FRAME_W-1:0] seq[$];
      seq.push_back(11'h000);
      seq.push_back(11'h7FF);
      seq.push_back(11'h600);
      seq.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_LISTEN, 5'd0});
      seq.push_back({CLS_DATA, 8'h41});
      seq.push_back(11'h2FF);
      seq.push_back({sld_pkg::CLS_CMD, sld_pkg::CMD_SDC});
      seq.push_back({sld_pkg::CLS_CMD, sld_pkg::CMD_DCL});
      seq.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_LISTEN, sld_pkg::LOW_UNADDRESS});
      seq.push_back({sld_pkg::CLS_CMD, 8'hFF});
      seq.push_back({sld_pkg::CLS_READY, sld_pkg::RDY_AAD_END});
      seq.push_back({sld_pkg::CLS_READY, AAD_FIRST | 8'd5});
      seq.push_back({sld_pkg::CLS_READY, AAD_FIRST});
      seq.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_TALK, 5'd5});
      seq.push_back({sld_pkg::CLS_READY, sld_pkg::RDY_SDI});
      repeat (8) seq.push_back(data_frame());
      seq.push_back({sld_pkg::CLS_READY, sld_pkg::RDY_SST});
      seq.push_back(data_frame());
      seq.push_back({sld_pkg::CLS_READY, sld_pkg::RDY_SAI});
      seq.push_back({sld_pkg::CLS_READY, sld_pkg::RDY_NRD});
      seq.push_back({sld_pkg::CLS_CMD, sld_pkg::CMD_SDC});
      seq.push_back(data_frame());
      seq.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_TALK, sld_pkg::LOW_UNADDRESS});
      seq.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_IFC, sld_pkg::LOW_IFC});
      seq.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_IFC, sld_pkg::LOW_AAU});
      foreach (seq[i]) send_frame(seq[i]);
   endtask

   task automatic random_frames(int unsigned count);
      logic [sld_pkg::FRAME_W-1:0] burst[$];
      logic [sld_pkg::ADDR_W-1:0] me;
      int unsigned sent;
      sent = 0;
      while (sent < count) begin
         burst.delete();
         me = tracker.my_addr;
         case ($urandom_range(9))
            0, 1: repeat ($urandom_range(1, 3)) burst.push_back(11'($urandom));
            2, 3: begin
               burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_TALK, me});
               burst.push_back({sld_pkg::CLS_READY, sld_pkg::RDY_SDI});
               repeat ($urandom_range(1, 10)) burst.push_back(data_frame());
               if ($urandom_range(1)) begin
                  burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_TALK,
                                   sld_pkg::LOW_UNADDRESS});
               end
            end
            4: begin
               burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_TALK, me});
               case ($urandom_range(3))
                  0: burst.push_back({sld_pkg::CLS_READY, sld_pkg::RDY_NRD});
                  1: burst.push_back({sld_pkg::CLS_READY, sld_pkg::RDY_SST});
                  2: burst.push_back({sld_pkg::CLS_READY, sld_pkg::RDY_SAI});
                  default: burst.push_back({sld_pkg::CLS_READY, 1'b0, 7'($urandom)});
               endcase
               repeat ($urandom_range(1, 2)) burst.push_back(data_frame());
            end
            5, 6: begin
               burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_LISTEN, me});
               repeat ($urandom_range(1, 6)) burst.push_back(data_frame());
               if ($urandom_range(1)) burst.push_back({sld_pkg::CLS_CMD, sld_pkg::CMD_SDC});
               burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_LISTEN,
                                sld_pkg::LOW_UNADDRESS});
            end
            7: begin
               if ($urandom_range(2) != 0) begin
                  burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_IFC, sld_pkg::LOW_AAU});
               end
               burst.push_back({sld_pkg::CLS_READY, AAD_FIRST | 8'($urandom_range(29))});
               if ($urandom_range(3) == 0) begin
                  burst.push_back({sld_pkg::CLS_READY,
                                   8'($urandom_range(8'hFF, sld_pkg::RDY_AAD_END))});
               end
            end
            8: begin
               case ($urandom_range(7))
                  0: burst.push_back({sld_pkg::CLS_CMD, sld_pkg::CMD_SDC});
                  1: burst.push_back({sld_pkg::CLS_CMD, sld_pkg::CMD_DCL});
                  2: burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_IFC, sld_pkg::LOW_IFC});
                  3: burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_LISTEN,
                                      sld_pkg::LOW_UNADDRESS});
                  4: burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_TALK,
                                      sld_pkg::LOW_UNADDRESS});
                  5: burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_LISTEN, 5'($urandom)});
                  6: burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_TALK, 5'($urandom)});
                  default: burst.push_back({sld_pkg::CLS_CMD, 8'($urandom)});
               endcase
            end
            default: begin
               repeat ($urandom_range(2, 4)) begin
                  case ($urandom_range(3))
                     0: burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_TALK, me});
                     1: burst.push_back({sld_pkg::CLS_CMD, sld_pkg::GRP_LISTEN, me});
                     2: burst.push_back(data_frame());
                     default: burst.push_back({sld_pkg::CLS_READY, 8'($urandom)});
                  endcase
               end
            end
         endcase
         foreach (burst[i]) send_frame(burst[i]);
         sent += burst.size();
      end
   endtask

   initial begin
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int unsigned p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            wait_drain();
         end
         setup_phase(p == 0 ? 4 : p);
         if (p == 0) directed_frames();
         random_frames(ITEMS_PER_PHASE);
      end
      wait_drain();
      repeat (10) @(posedge clock);
      if (tracker.faults == 0 && tracker.expected_results.size() == 0) begin
         $display("serial_loop_display_device verification clean");
      end else begin
         $display("serial_loop_display_device verification failed");
      end
      $finish;
   end

endmodule
